FILE: design/fsq_pkg.sv
// Shared types and constants for the four-square pair decrypter.
package fsq_pkg;

    // Default side of a key square; the grid is side x side.
    localparam int SQUARE_SIDE_DEF = 5;

    // Width of the key_position and letter fields.
    localparam int POS_WIDTH    = 5;
    localparam int LETTER_WIDTH = 8;

    // Transaction commands.
    typedef enum logic [1:0] {
        CMD_WRITE_ONE = 2'd0,
        CMD_WRITE_TWO = 2'd1,
        CMD_DECODE    = 2'd2
    } cmd_t;

    // Control to one key-search lane.
    typedef struct packed {
        logic key_we;    // store key_letter at key_position
        logic stage_en;  // capture the search result of this transaction
    } lane_ctrl_t;

    // Standard alphabet square, row major, no J.
    localparam logic [LETTER_WIDTH-1:0] PLAIN_SQUARE [25] = '{
        8'h41, 8'h42, 8'h43, 8'h44, 8'h45,
        8'h46, 8'h47, 8'h48, 8'h49, 8'h4B,
        8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50,
        8'h51, 8'h52, 8'h53, 8'h54, 8'h55,
        8'h56, 8'h57, 8'h58, 8'h59, 8'h5A
    };

endpackage

FILE: design/fsq_key_lane.sv
// One key square with its parallel letter search and row/column capture.
module fsq_key_lane #(
    parameter int SQUARE_SIDE = fsq_pkg::SQUARE_SIDE_DEF
) (
    input  logic                             clk,
    input  fsq_pkg::lane_ctrl_t              ctrl,
    input  logic [fsq_pkg::POS_WIDTH-1:0]    key_position,
    input  logic [fsq_pkg::LETTER_WIDTH-1:0] key_letter,
    input  logic [fsq_pkg::LETTER_WIDTH-1:0] search_letter,
    output logic [SQUARE_SIDE-1:0]           row_oh,
    output logic [SQUARE_SIDE-1:0]           col_oh,
    output logic                             found
);
    import fsq_pkg::*;

    localparam int CELLS = SQUARE_SIDE * SQUARE_SIDE;

    logic [LETTER_WIDTH-1:0] key_reg [CELLS];
    logic [CELLS-1:0]        match;
    logic [CELLS-1:0]        lowest;
    logic [SQUARE_SIDE-1:0]  row_next;
    logic [SQUARE_SIDE-1:0]  col_next;
    logic [SQUARE_SIDE-1:0]  row_oh_reg;
    logic [SQUARE_SIDE-1:0]  col_oh_reg;
    logic                    found_reg;

    // Key entry write; out-of-range positions match no entry
    always_ff @(posedge clk)
    begin
        for (int p = 0; p < CELLS; p++)
        begin
            if (ctrl.key_we && key_position == POS_WIDTH'(p))
            begin
                key_reg[p] <= key_letter;
            end
        end
    end

    // Compare every entry at once
    always_comb
    begin
        for (int p = 0; p < CELLS; p++)
        begin
            match[p] = (key_reg[p] == search_letter);
        end
    end

    // Isolate lowest match, fold to row and column one-hots
    assign lowest = match & (~match + CELLS'(1));

    always_comb
    begin
        row_next = '0;
        col_next = '0;
        for (int r = 0; r < SQUARE_SIDE; r++)
        begin
            for (int c = 0; c < SQUARE_SIDE; c++)
            begin
                row_next[r] = row_next[r] | lowest[r*SQUARE_SIDE + c];
                col_next[c] = col_next[c] | lowest[r*SQUARE_SIDE + c];
            end
        end
    end

    // Search result stage
    always_ff @(posedge clk)
    begin
        if (ctrl.stage_en)
        begin
            row_oh_reg <= row_next;
            col_oh_reg <= col_next;
            found_reg  <= |match;
        end
    end

    assign row_oh = row_oh_reg;
    assign col_oh = col_oh_reg;
    assign found  = found_reg;

endmodule

FILE: design/fsq_merge.sv
// Combines both lane results into the plain letter pair and holds the result.
module fsq_merge #(
    parameter int SQUARE_SIDE = fsq_pkg::SQUARE_SIDE_DEF
) (
    input  logic                             clk,
    input  logic                             load,
    input  logic [SQUARE_SIDE-1:0]           row_one,
    input  logic [SQUARE_SIDE-1:0]           col_one,
    input  logic                             found_one,
    input  logic [SQUARE_SIDE-1:0]           row_two,
    input  logic [SQUARE_SIDE-1:0]           col_two,
    input  logic                             found_two,
    output logic [fsq_pkg::LETTER_WIDTH-1:0] plain_first,
    output logic [fsq_pkg::LETTER_WIDTH-1:0] plain_second,
    output logic                             not_found
);
    import fsq_pkg::*;

    logic [LETTER_WIDTH-1:0] first_next;
    logic [LETTER_WIDTH-1:0] second_next;
    logic                    both_found;
    logic [LETTER_WIDTH-1:0] plain_first_reg;
    logic [LETTER_WIDTH-1:0] plain_second_reg;
    logic                    not_found_reg;

    assign both_found = found_one & found_two;

    // Swap corners: row of one with column of two, row of two with column of one
    always_comb
    begin
        first_next  = '0;
        second_next = '0;
        for (int r = 0; r < SQUARE_SIDE; r++)
        begin
            for (int c = 0; c < SQUARE_SIDE; c++)
            begin
                if (row_one[r] && col_two[c])
                begin
                    first_next = first_next | PLAIN_SQUARE[r*SQUARE_SIDE + c];
                end
                if (row_two[r] && col_one[c])
                begin
                    second_next = second_next | PLAIN_SQUARE[r*SQUARE_SIDE + c];
                end
            end
        end
    end

    // Output register; letters forced to zero on a miss
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            plain_first_reg  <= both_found ? first_next  : '0;
            plain_second_reg <= both_found ? second_next : '0;
            not_found_reg    <= ~both_found;
        end
    end

    assign plain_first  = plain_first_reg;
    assign plain_second = plain_second_reg;
    assign not_found    = not_found_reg;

endmodule

FILE: design/four_square_pair_decrypt_top.sv
// Top level of the four-square pair decrypter: handshake control, two lanes, merge.
//
//  Channel   Valid          Stall          Payload
//  -------   ------------   ------------   -----------------------------------------------
//  item      item_valid     item_stall     cmd, key_position, key_letter,
//                                          cipher_first, cipher_second
//  result    result_valid   result_stall   plain_first, plain_second, not_found
//
//  A decode transaction gives its result after passing through the lane compare
//  stage and then the merge output register. One transaction per cycle is
//  sustained while result_stall is low; key writes give no result.
//  Reset clears the stage valid flags only; key squares hold garbage until written.
//  A stalled result backs up through the lane stage into item_stall.
module four_square_pair_decrypt_top #(
    parameter int SQUARE_SIDE = fsq_pkg::SQUARE_SIDE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic [1:0]                       cmd,
    input  logic [fsq_pkg::POS_WIDTH-1:0]    key_position,
    input  logic [fsq_pkg::LETTER_WIDTH-1:0] key_letter,
    input  logic [fsq_pkg::LETTER_WIDTH-1:0] cipher_first,
    input  logic [fsq_pkg::LETTER_WIDTH-1:0] cipher_second,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [fsq_pkg::LETTER_WIDTH-1:0] plain_first,
    output logic [fsq_pkg::LETTER_WIDTH-1:0] plain_second,
    output logic                             not_found
);
    import fsq_pkg::*;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic                   result_valid_reg;
    logic                   result_valid_next;
    logic                   advance;
    logic                   accept;
    logic                   is_decode;
    lane_ctrl_t             ctrl_one;
    lane_ctrl_t             ctrl_two;
    logic [SQUARE_SIDE-1:0] row_one;
    logic [SQUARE_SIDE-1:0] col_one;
    logic                   found_one;
    logic [SQUARE_SIDE-1:0] row_two;
    logic [SQUARE_SIDE-1:0] col_two;
    logic                   found_two;

    // Handshake and pipeline advance
    assign advance    = ~result_valid_reg | ~result_stall;
    assign item_stall = s1_valid_reg & ~advance;
    assign accept     = item_valid & ~item_stall;
    assign is_decode  = (cmd_t'(cmd) == CMD_DECODE);

    always_comb
    begin
        ctrl_one.key_we   = accept && cmd_t'(cmd) == CMD_WRITE_ONE;
        ctrl_one.stage_en = accept && is_decode;
        ctrl_two.key_we   = accept && cmd_t'(cmd) == CMD_WRITE_TWO;
        ctrl_two.stage_en = accept && is_decode;
    end

    // Stage valid flags
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = is_decode;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        result_valid_next = advance ? s1_valid_reg : result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

    // Lane one searches key square one for the first letter
    fsq_key_lane #(
        .SQUARE_SIDE(SQUARE_SIDE)
    ) u_lane_one (
        .clk          (clk),
        .ctrl         (ctrl_one),
        .key_position (key_position),
        .key_letter   (key_letter),
        .search_letter(cipher_first),
        .row_oh       (row_one),
        .col_oh       (col_one),
        .found        (found_one)
    );

    // Lane two searches key square two for the second letter
    fsq_key_lane #(
        .SQUARE_SIDE(SQUARE_SIDE)
    ) u_lane_two (
        .clk          (clk),
        .ctrl         (ctrl_two),
        .key_position (key_position),
        .key_letter   (key_letter),
        .search_letter(cipher_second),
        .row_oh       (row_two),
        .col_oh       (col_two),
        .found        (found_two)
    );

    // Merge into the output register
    fsq_merge #(
        .SQUARE_SIDE(SQUARE_SIDE)
    ) u_merge (
        .clk         (clk),
        .load        (advance & s1_valid_reg),
        .row_one     (row_one),
        .col_one     (col_one),
        .found_one   (found_one),
        .row_two     (row_two),
        .col_two     (col_two),
        .found_two   (found_two),
        .plain_first (plain_first),
        .plain_second(plain_second),
        .not_found   (not_found)
    );

`ifndef SYNTHESIS
    // A miss always carries zero letters
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && not_found |-> plain_first == '0 && plain_second == '0)
        else $error("not_found result with nonzero letters");

    // Input is held back only by a full lane stage
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> s1_valid_reg)
        else $error("item_stall with empty lane stage");

    // Key writes never fill the lane stage
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_decode |=> !s1_valid_reg)
        else $error("non-decode transaction produced a pending result");

    // A pending decode reaches the output once the output frees up
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance |=> result_valid_reg)
        else $error("lane result lost on advance");
`endif

endmodule
